/* rtl/spp_pkg.sv */
// Package: shared types, constants and helper functions of the starfield projector.
package spp_pkg;

  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 3;
  localparam int XyW      = 12;
  localparam int ZW       = 10;
  localparam int OffW     = 24;
  localparam int WordW    = 16;
  localparam int FifoDepthDefault = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PITCH  = 3'd2,
    REG_SPEED_X = 3'd3,
    REG_SPEED_Y = 3'd4,
    REG_SPEED_Z = 3'd5
  } reg_idx_t;

  // Request after wrap: produced by the front part.
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic [7:0]            z;
  } star_req_t;

  // Reciprocal table entry: ceil(2^20 / z) for z in 1..255 (21 bits covers z=1).
  // Evaluated only on constant depths, so it folds into a fixed table.
  function automatic logic [20:0] recip(input logic [7:0] z);
    logic [20:0] num;
    logic [20:0] q;
    logic [8:0]  rem;
    num = 21'(22'h100000 + 22'(z) - 22'd1);
    q = '0;
    rem = '0;
    if (z != 8'd0) begin
      for (int b = 20; b >= 0; b--) begin
        rem = {rem[7:0], num[b]};
        if (rem >= {1'b0, z}) begin
          rem = rem - {1'b0, z};
          q[b] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  function automatic logic [WordW-1:0] grey_word(input logic [7:0] z);
    logic [3:0] lv;
    lv = 4'(5'd16 - {1'b0, z[7:4]});
    return {lv, 1'b0, lv, 2'b00, lv, 1'b0};
  endfunction

endpackage

/* rtl/spp_front.sv */
// Front part: wraps depth and position of each request.
module spp_front import spp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  ready,
  input  logic signed [XyW-1:0] star_x,
  input  logic signed [XyW-1:0] star_y,
  input  logic signed [ZW-1:0]  star_z,
  input  logic [11:0]           screen_width,
  input  logic [11:0]           screen_height,
  output logic                  q_valid,
  input  logic                  q_ready,
  output star_req_t             q_data
);

  logic signed [12:0] half_w, half_h;
  logic signed [12:0] xw, yw;
  logic [7:0] zw;

  assign half_w = $signed({2'b00, screen_width[11:1]});
  assign half_h = $signed({2'b00, screen_height[11:1]});

  function automatic logic signed [12:0] wrap(input logic signed [12:0] v,
                                              input logic signed [12:0] h);
    logic signed [12:0] r;
    r = v;
    if (r < -h) r = h;
    if (r > h) r = -h;
    return r;
  endfunction

  always_comb begin
    xw = wrap(13'(star_x), half_w);
    yw = wrap(13'(star_y), half_h);
    if (star_z < 10'sd1) zw = 8'd255;
    else if (star_z > 10'sd255) zw = 8'd1;
    else zw = star_z[7:0];
  end

  // Register stage: take a new request while the held one drains.
  assign ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (ready) begin
      q_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      q_data.x <= xw[XyW-1:0];
      q_data.y <= yw[XyW-1:0];
      q_data.z <= zw;
    end
  end

endmodule

/* rtl/spp_fifo.sv */
// Short queue between the front and back parts.
module spp_fifo import spp_pkg::*; #(
  parameter int Depth = FifoDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  star_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output star_req_t out_data
);

  localparam int AW = $clog2(Depth);

  star_req_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ready  = count != (AW+1)'(Depth);
  assign out_valid = count != '0;
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  assign out_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

/* rtl/spp_back.sv */
// Back part: projection pipeline, offset, grey level and velocity update.
module spp_back import spp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  star_req_t             in_data,
  input  logic [11:0]           screen_width,
  input  logic [11:0]           screen_height,
  input  logic [12:0]           line_pitch,
  input  logic signed [7:0]     speed_x,
  input  logic signed [7:0]     speed_y,
  input  logic signed [7:0]     speed_z,
  output logic                  valid,
  input  logic                  ready,
  output logic signed [XyW-1:0] next_x,
  output logic signed [XyW-1:0] next_y,
  output logic signed [ZW-1:0]  next_z,
  output logic                  plot,
  output logic [OffW-1:0]       pixel_offset,
  output logic [WordW-1:0]      pixel_word
);

  // Pipeline with global advance: stall all stages when the output is held.
  logic adv;
  logic v1, v2, v3, v4;
  assign adv = !valid || ready;
  assign in_ready = adv;

  // Constant reciprocal table indexed by wrapped depth.
  logic [20:0] recip_rom [256];
  for (genvar g = 0; g < 256; g++) begin : g_recip
    assign recip_rom[g] = recip(8'(g));
  end

  // Stage 1: magnitudes and reciprocal lookup (|coord*128| < 2^18, recip < 2^21).
  logic [18:0] ax, ay;
  logic        sx, sy;
  logic [20:0] rc;
  logic [7:0]  z1;
  logic signed [11:0] x1, y1;
  logic [39:0] px_prod, py_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= in_data.x[11] ? 19'(-{{7{in_data.x[11]}}, in_data.x} <<< 7)
                          : 19'({7'd0, in_data.x} << 7);
      ay <= in_data.y[11] ? 19'(-{{7{in_data.y[11]}}, in_data.y} <<< 7)
                          : 19'({7'd0, in_data.y} << 7);
      sx <= in_data.x[11];
      sy <= in_data.y[11];
      rc <= recip_rom[in_data.z];
      z1 <= in_data.z;
      x1 <= in_data.x;
      y1 <= in_data.y;
    end
  end

  // Stage 2: multiply.
  logic sx2, sy2;
  logic [18:0] ax2, ay2;
  logic [7:0] z2;
  logic signed [11:0] x2, y2;
  always_ff @(posedge clk) begin
    if (adv) begin
      px_prod <= 40'(ax) * 40'(rc);
      py_prod <= 40'(ay) * 40'(rc);
      sx2 <= sx; sy2 <= sy; ax2 <= ax; ay2 <= ay;
      z2 <= z1; x2 <= x1; y2 <= y1;
    end
  end

  // Stage 3: correct the quotient estimate, sign, add centre, compare.
  logic [18:0] qx0, qy0, qx, qy;
  logic [26:0] chk_x, chk_y;
  always_comb begin
    qx0 = px_prod[38:20];
    qy0 = py_prod[38:20];
    chk_x = 27'(qx0) * 27'(z2);
    chk_y = 27'(qy0) * 27'(z2);
    qx = (chk_x > 27'(ax2)) ? qx0 - 1'b1 : qx0;
    qy = (chk_y > 27'(ay2)) ? qy0 - 1'b1 : qy0;
  end

  logic signed [20:0] pxs, pys;
  logic [7:0] z3;
  logic signed [11:0] x3, y3;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxs <= (sx2 ? -21'(qx) : 21'(qx)) + 21'(screen_width[11:1]);
      pys <= (sy2 ? -21'(qy) : 21'(qy)) + 21'(screen_height[11:1]);
      z3 <= z2; x3 <= x2; y3 <= y2;
    end
  end

  // Stage 4: plot test and offset multiply.
  logic plot4;
  logic [OffW-1:0] off4;
  logic [7:0] z4;
  logic signed [11:0] x4, y4;
  logic p_ok;
  assign p_ok = pxs > 21'sd0 && pxs < $signed(21'(screen_width)) &&
                pys > 21'sd0 && pys < $signed(21'(screen_height));
  always_ff @(posedge clk) begin
    if (adv) begin
      plot4 <= p_ok;
      off4  <= p_ok ? OffW'(24'(pys[11:0]) * 24'(line_pitch) + 24'(pxs[11:0])) : '0;
      z4 <= z3; x4 <= x3; y4 <= y3;
    end
  end

  // Output register: saturating velocity update.
  logic signed [13:0] nx, ny;
  logic signed [10:0] nz;
  always_comb begin
    nx = 14'(x4) + 14'(speed_x);
    ny = 14'(y4) + 14'(speed_y);
    nz = $signed({3'b000, z4}) - 11'(speed_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      next_x <= (nx > 14'sd2047) ? 12'sd2047 : (nx < -14'sd2048) ? -12'sd2048 : nx[11:0];
      next_y <= (ny > 14'sd2047) ? 12'sd2047 : (ny < -14'sd2048) ? -12'sd2048 : ny[11:0];
      next_z <= (nz > 11'sd511) ? 10'sd511 : nz[9:0];
      plot <= plot4;
      pixel_offset <= off4;
      pixel_word <= grey_word(z4);
    end
  end

  assert property (@(posedge clk) disable iff (rst) (valid && !ready) |=> valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) (valid && !plot) |-> pixel_offset == '0)
    else $error("offset nonzero without plot");
  assert property (@(posedge clk) disable iff (rst) (v4 && adv) |=> valid)
    else $error("pipeline lost a request");

endmodule

/* rtl/starfield_point_projector_core.sv */
// Top level: starfield point projector, front wrap, queue and projection back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | valid / ready      | star_x, star_y, star_z
//  output   | out_valid/out_ready| next_x, next_y, next_z, plot, offset, word
//  config   | cfg_we             | cfg_idx, cfg_data
//
// One request per clock sustained while the output is not stalled; the path from
// the accepting edge to out_valid runs through the front register, queue write,
// four pipeline stages and output register. The reciprocal multiply and its correction set depth.
// Reset restores the screen 640x480, pitch 640, speeds (0,2,4), empties all.
// An output stall freezes the back pipeline; the queue then absorbs requests
// until full, after which ready drops at the input.
module starfield_point_projector_core import spp_pkg::*; #(
  parameter int FifoDepth = FifoDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  ready,
  input  logic signed [XyW-1:0] star_x,
  input  logic signed [XyW-1:0] star_y,
  input  logic signed [ZW-1:0]  star_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [XyW-1:0] next_x,
  output logic signed [XyW-1:0] next_y,
  output logic signed [ZW-1:0]  next_z,
  output logic                  plot,
  output logic [OffW-1:0]       pixel_offset,
  output logic [WordW-1:0]      pixel_word,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_idx,
  input  logic [CfgDataW-1:0]   cfg_data
);

  logic [11:0] screen_width, screen_height;
  logic [12:0] line_pitch;
  logic signed [7:0] speed_x, speed_y, speed_z;

  // Register file: hold values until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd640;
      screen_height <= 12'd480;
      line_pitch    <= 13'd640;
      speed_x       <= 8'sd0;
      speed_y       <= 8'sd2;
      speed_z       <= 8'sd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:   screen_width  <= cfg_data[11:0];
        REG_HEIGHT:  screen_height <= cfg_data[11:0];
        REG_PITCH:   line_pitch    <= cfg_data[12:0];
        REG_SPEED_X: speed_x       <= cfg_data[7:0];
        REG_SPEED_Y: speed_y       <= cfg_data[7:0];
        REG_SPEED_Z: speed_z       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic      f_valid, f_ready, b_valid, b_ready;
  star_req_t f_data, b_data;

  spp_front u_front (
    .clk, .rst, .valid, .ready, .star_x, .star_y, .star_z,
    .screen_width, .screen_height,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  spp_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  spp_back u_back (
    .clk, .rst, .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
    .screen_width, .screen_height, .line_pitch, .speed_x, .speed_y, .speed_z,
    .valid(out_valid), .ready(out_ready),
    .next_x, .next_y, .next_z, .plot, .pixel_offset, .pixel_word
  );

endmodule

/* tb/sv/starfield_point_projector_core_tb.sv */
// Testbench for the starfield point projector: directed table, random streams, config sweeps.
`timescale 1ns / 100ps

module starfield_point_projector_core_tb;
  import spp_pkg::*;

  // One projected star as the block reports it.
  typedef struct {
    logic signed [XyW-1:0] nx;
    logic signed [XyW-1:0] ny;
    logic signed [ZW-1:0]  nz;
    logic                  pl;
    logic [OffW-1:0]       off;
    logic [WordW-1:0]      word;
  } star_proj_t;

  // One row of the directed table; known marks rows whose result is typed in.
  typedef struct {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    bit                    known;
    star_proj_t            res;
  } star_row_t;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  valid = 1'b0;
  logic                  ready;
  logic signed [XyW-1:0] star_x = '0;
  logic signed [XyW-1:0] star_y = '0;
  logic signed [ZW-1:0]  star_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [XyW-1:0] next_x;
  logic signed [XyW-1:0] next_y;
  logic signed [ZW-1:0]  next_z;
  logic                  plot;
  logic [OffW-1:0]       pixel_offset;
  logic [WordW-1:0]      pixel_word;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;

  starfield_point_projector_core dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers.
  int scr_w, scr_h, pitch, vel_x, vel_y, vel_z;

  star_proj_t pending_proj[$];
  star_proj_t row_override[$];
  bit         row_flag[$];
  bit         req_taken = 1'b0;
  int         failures = 0;
  int         stars_in = 0;
  int         stars_out = 0;
  int         stars_plotted = 0;
  int         quiet_cycles = 0;
  int         phases = 0;
  int         burst_left = 0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int wrap_to_half(int v, int half);
    if (v < -half) v = half;
    if (v > half) v = -half;
    return v;
  endfunction

  // Wrap, project in perspective, classify and advance one star.
  function automatic star_proj_t project_star(logic signed [XyW-1:0] sx,
                                              logic signed [XyW-1:0] sy,
                                              logic signed [ZW-1:0] sz);
    star_proj_t p;
    int x, y, z, px, py, lvl;
    bit [31:0] off32;
    x = sx;
    y = sy;
    z = sz;
    if (z < 1) z = 255;
    if (z > 255) z = 1;
    x = wrap_to_half(x, scr_w / 2);
    y = wrap_to_half(y, scr_h / 2);
    px = (x * 128) / z + scr_w / 2;
    py = (y * 128) / z + scr_h / 2;
    p.pl = (px > 0 && px < scr_w && py > 0 && py < scr_h);
    off32 = 32'(py) * 32'(pitch) + 32'(px);
    p.off = p.pl ? off32[OffW-1:0] : '0;
    lvl = (16 - z / 16) & 15;
    p.word = 16'((lvl << 12) | (lvl << 7) | (lvl << 1));
    p.nx = XyW'(clamp(x + vel_x, -2048, 2047));
    p.ny = XyW'(clamp(y + vel_y, -2048, 2047));
    p.nz = ZW'(clamp(z - vel_z, -512, 511));
    return p;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Input side: record each accepted request and queue its projection.
  // Output side: compare each accepted result with the oldest projection.
  always @(posedge clk) begin
    req_taken <= !rst && valid && ready;
    if (!rst) begin
      if ((valid && ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (valid && ready) begin
        star_proj_t p;
        p = project_star(star_x, star_y, star_z);
        // Directed rows with a typed-in result take that one instead.
        if (row_flag.size() != 0) begin
          if (row_flag.pop_front()) p = row_override.pop_front();
        end
        pending_proj.push_back(p);
        stars_in++;
      end
      if (out_valid && out_ready) begin
        stars_out++;
        if (pending_proj.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          star_proj_t e;
          e = pending_proj.pop_front();
          check_field("next_x", 32'(e.nx) & 32'hFFF, 32'(next_x) & 32'hFFF);
          check_field("next_y", 32'(e.ny) & 32'hFFF, 32'(next_y) & 32'hFFF);
          check_field("next_z", 32'(e.nz) & 32'h3FF, 32'(next_z) & 32'h3FF);
          check_field("plot", e.pl, plot);
          check_field("pixel_offset", e.off, pixel_offset);
          check_field("pixel_word", e.word, pixel_word);
          if (plot) stars_plotted++;
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Watchdog: no handshake for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: stall pattern rotates through four modes: always ready, coin flips,
  // long stalls with short windows, and mostly ready.
  always @(negedge clk) begin
    int mode;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      mode = int'(($time / 480) % 4);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 15) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Drive one request; valid stays high across back-to-back requests.
  task automatic send_star(logic signed [XyW-1:0] x, logic signed [XyW-1:0] y,
                           logic signed [ZW-1:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    valid = 1'b1;
    star_x = x;
    star_y = y;
    star_z = z;
    do @(negedge clk); while (!req_taken);
  endtask

  // Hold off until every projection is back and the pipe has flushed.
  task automatic drain_all();
    valid = 1'b0;
    burst_left = 0;
    while (pending_proj.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = CfgDataW'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_WIDTH:   scr_w = value & 32'hFFF;
      REG_HEIGHT:  scr_h = value & 32'hFFF;
      REG_PITCH:   pitch = value & 32'h1FFF;
      REG_SPEED_X: vel_x = int'(signed'(8'(value)));
      REG_SPEED_Y: vel_y = int'(signed'(8'(value)));
      default:     vel_z = int'(signed'(8'(value)));
    endcase
  endtask

  task automatic set_screen(int w, int h, int p, int vx, int vy, int vz);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PITCH, p);
    write_reg(REG_SPEED_X, vx & 8'hFF);
    write_reg(REG_SPEED_Y, vy & 8'hFF);
    write_reg(REG_SPEED_Z, vz & 8'hFF);
    phases++;
  endtask

  // Mostly stars on screen with depth in range; the rest is raw noise that
  // exercises the wraps and every bit of the fields.
  task automatic random_stars(int count);
    int hw, hh;
    repeat (count) begin
      hw = scr_w / 2;
      hh = scr_h / 2;
      if ($urandom_range(0, 9) < 6)
        send_star(XyW'($urandom_range(0, 2 * hw) - hw),
                  XyW'($urandom_range(0, 2 * hh) - hh),
                  ZW'($urandom_range(1, 255)));
      else
        send_star(XyW'($urandom), XyW'($urandom), ZW'($urandom));
    end
  endtask

  // Directed rows at the reset screen (640x480, pitch 640, speeds 0,2,4).
  star_row_t dir_tab[] = '{
    '{12'sd0, 12'sd0, 10'sd128, 1'b1, '{12'sd0, 12'sd2, 10'sd124, 1'b1, 24'd153920, 16'd33808}},
    '{12'sd0, 12'sd0, 10'sd0, 1'b1, '{12'sd0, 12'sd2, 10'sd251, 1'b1, 24'd153920, 16'd4226}},
    '{12'sd0, 12'sd0, -10'sd512, 1'b1, '{12'sd0, 12'sd2, 10'sd251, 1'b1, 24'd153920, 16'd4226}},
    '{12'sd0, 12'sd0, 10'sd511, 1'b1, '{12'sd0, 12'sd2, -10'sd3, 1'b1, 24'd153920, 16'd0}},
    '{12'sd0, 12'sd0, 10'sd256, 1'b1, '{12'sd0, 12'sd2, -10'sd3, 1'b1, 24'd153920, 16'd0}},
    '{12'sd2047, 12'sd2047, 10'sd1, 1'b0, '{default: '0}},
    '{-12'sd2048, -12'sd2048, 10'sd1, 1'b0, '{default: '0}},
    '{-12'sd2048, 12'sd2047, 10'sd255, 1'b0, '{default: '0}},
    '{12'sd320, 12'sd240, 10'sd16, 1'b0, '{default: '0}},
    '{-12'sd320, -12'sd240, 10'sd16, 1'b0, '{default: '0}},
    '{12'sd321, -12'sd241, 10'sd100, 1'b0, '{default: '0}},
    '{-12'sd321, 12'sd241, 10'sd100, 1'b0, '{default: '0}},
    '{12'sd319, 12'sd239, 10'sd255, 1'b0, '{default: '0}},
    '{-12'sd319, -12'sd239, 10'sd255, 1'b0, '{default: '0}},
    '{12'sd100, -12'sd100, 10'sd64, 1'b0, '{default: '0}},
    '{-12'sd1, -12'sd1, 10'sd1, 1'b0, '{default: '0}},
    '{12'sd5, 12'sd3, -10'sd1, 1'b0, '{default: '0}},
    '{12'sd0, 12'sd0, 10'sd255, 1'b0, '{default: '0}},
    '{12'sd0, 12'sd0, 10'sd15, 1'b0, '{default: '0}}
  };

  initial begin
    scr_w = 640; scr_h = 480; pitch = 640;
    vel_x = 0; vel_y = 2; vel_z = 4;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      row_flag.push_back(dir_tab[i].known);
      if (dir_tab[i].known) row_override.push_back(dir_tab[i].res);
    end
    foreach (dir_tab[i]) send_star(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z);
    random_stars(90);
    drain_all();

    // Sweep screen sizes and speeds, extremes first.
    set_screen(2, 2, 1, -128, -128, -128);
    random_stars(80);
    drain_all();
    set_screen(2048, 2048, 4096, 127, 127, 127);
    random_stars(90);
    drain_all();
    set_screen(4095, 4095, 8191, 127, -128, 127);
    random_stars(80);
    drain_all();
    set_screen(0, 1, 0, -1, 1, -1);
    random_stars(40);
    drain_all();
    set_screen(800, 600, 1024, 3, -5, 9);
    random_stars(90);
    drain_all();
    set_screen($urandom_range(2, 2048), $urandom_range(2, 2048), $urandom_range(1, 4096),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    random_stars(90);
    drain_all();
    set_screen(320, 200, 320, 0, 0, 1);
    random_stars(70);
    drain_all();

    $display("Sent %0d stars, checked %0d results, %0d on screen.",
             stars_in, stars_out, stars_plotted);
    $display("Covered reset config and %0d screen/speed settings.", phases);
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
